// File: rtl/wavetable_oscillator_adsr_top_assert.svh
// ---------------------------------------------------------------------------
// assertion macros for the wavetable oscillator checker
// ---------------------------------------------------------------------------
`ifndef WAVETABLE_OSCILLATOR_ADSR_TOP_ASSERT_SVH
`define WAVETABLE_OSCILLATOR_ADSR_TOP_ASSERT_SVH

// property checked outside reset only
`define WOSC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked at every edge, reset included
`define WOSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/wosc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wosc_pkg
// shared constants, operation codes and the quarter-wave sine table
// ---------------------------------------------------------------------------
package wosc_pkg;

  localparam int unsigned PHASE_W    = 26;
  localparam int unsigned TABLE_BITS = 10;
  localparam int unsigned QTAB_DEPTH = 256;
  localparam int unsigned ENV_ONE    = 32768;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2,
    OP_UNUSED   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_ATTACK  = 2'd0,
    REG_DECAY   = 2'd1,
    REG_SUSTAIN = 2'd2,
    REG_RELEASE = 2'd3
  } reg_e;

  typedef logic [15:0] qtab_t [QTAB_DEPTH];

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam logic [63:0] SINE_AMP    = 64'd32767;

  // rounded magnitude of sin(pi/2 * k/256) * amp, truncated Q30 series to x^11
  function automatic logic [15:0] qsine_mag(input int unsigned k);
    logic [63:0] f;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    f  = 64'(k) << 22;
    x  = (f * Q30_HALF_PI) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
    t  = (x * t) >> 30;
    if (t > Q30_ONE) begin
      t = Q30_ONE;
    end
    s = (t * SINE_AMP + (64'd1 << 29)) >> 30;
    return s[15:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t tab;
    for (int k = 0; k < QTAB_DEPTH; k++) begin
      tab[k] = qsine_mag(k);
    end
    return tab;
  endfunction

  localparam qtab_t       QTAB       = build_qtab();
  localparam logic [15:0] SINE_PEAK  = qsine_mag(QTAB_DEPTH);

endpackage

// File: rtl/wosc_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wosc_div
// restoring divider, one quotient bit per cycle, 16-bit quotient
// ---------------------------------------------------------------------------
module wosc_div import wosc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,  // must be below divisor << 16
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [15:0] quotient_o
);

  logic [15:0] rem_q, rem_d;
  logic [15:0] sh_q, sh_d;
  logic [15:0] dvs_q;
  logic [3:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [16:0] trial;
  logic        qbit;

  always_comb begin
    trial = {rem_q, sh_q[15]};
    qbit  = (trial >= {1'b0, dvs_q});
    rem_d = qbit ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];
    sh_d  = {sh_q[14:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'hf) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[31:16];
      sh_q  <= dividend_i[15:0];
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= sh_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = sh_q;

endmodule

// File: rtl/wavetable_oscillator_adsr_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wavetable_oscillator_adsr_top
// sine wavetable oscillator with a linear adsr envelope
// ---------------------------------------------------------------------------
// One transfer on the slave side is one event: a sample tick, a note-on or a
// note-off (s_axis_tuser). Note events give no result. A tick gives one result
// on the master side and keeps the block busy: through F_SMUL and F_DONE when
// the envelope value is a plain level (sustain, idle, stage end), and through
// F_EMUL and F_DIV first when a ramp value is needed, where the 16-step serial
// divider follows one pass through the shared 17x17 multiplier; the same
// multiplier then scales the sine sample. A finished result waits in the
// output register while the next event is taken. The sine ROM holds one
// quarter wave; the other quadrants are mirrored and negated.
module wavetable_oscillator_adsr_top import wosc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [25:0] note_increment, [31:26] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [15:0] sample_out, [31:16] envelope_level
);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_ATTACK  = 3'd1,
    ST_DECAY   = 3'd2,
    ST_SUSTAIN = 3'd3,
    ST_RELEASE = 3'd4
  } stage_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_EMUL,
    F_DIV,
    F_SMUL,
    F_DONE
  } fsm_e;

  localparam logic [16:0] ONE17 = 17'(ENV_ONE);
  localparam logic [15:0] ONE16 = 16'(ENV_ONE);

  // configuration registers
  logic [15:0] attack_q, decay_q, sustain_q, release_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= 16'd441;
      decay_q   <= 16'd4410;
      sustain_q <= 16'd22938;
      release_q <= 16'd8820;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_addr_i))
        REG_ATTACK:  attack_q  <= cfg_wdata_i;
        REG_DECAY:   decay_q   <= cfg_wdata_i;
        REG_SUSTAIN: sustain_q <= cfg_wdata_i;
        REG_RELEASE: release_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  fsm_e                fsm_q;
  stage_e              stage_q;
  logic [15:0]         cnt_q;
  logic [PHASE_W-1:0]  phase_q, step_q;
  logic signed [16:0]  op_a_q, op_b_q;
  logic [15:0]         div_n_q;
  logic                sub_q;
  logic signed [15:0]  sine_q;
  logic [15:0]         env_q;
  logic [15:0]         smp_q;
  logic                m_valid_q;
  logic [15:0]         m_smp_q, m_env_q;

  logic       in_xfer;
  op_e        op;

  assign op            = op_e'(s_axis_tuser);
  assign s_axis_tready = (fsm_q == F_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // envelope step for a tick, from the current stage and counter
  logic [15:0]  sus;
  logic [15:0]  len_a, len_d, len_r, n;
  logic [16:0]  cnt1;
  logic         direct;
  logic [15:0]  env_dir;
  logic [16:0]  a_v, b_v;
  logic         sub_v;
  stage_e       stage_d;
  logic [15:0]  cnt_d;

  always_comb begin
    sus     = (sustain_q > ONE16) ? ONE16 : sustain_q;
    len_a   = (attack_q == '0) ? 16'd1 : attack_q;
    len_d   = (decay_q == '0) ? 16'd1 : decay_q;
    len_r   = (release_q == '0) ? 16'd1 : release_q;
    cnt1    = {1'b0, cnt_q} + 17'd1;
    n       = 16'd1;
    direct  = 1'b1;
    env_dir = '0;
    a_v     = '0;
    b_v     = '0;
    sub_v   = 1'b0;
    stage_d = stage_q;
    cnt_d   = cnt_q;
    case (stage_q)
      ST_ATTACK: begin
        n = len_a;
        if (cnt_q >= n) begin
          env_dir = ONE16;
        end else begin
          direct = 1'b0;
          a_v    = {1'b0, cnt_q};
          b_v    = ONE17;
        end
        if (cnt1 >= {1'b0, n}) begin
          stage_d = ST_DECAY;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt1[15:0];
        end
      end
      ST_DECAY: begin
        n = len_d;
        if (cnt_q >= n) begin
          env_dir = sus;
        end else begin
          direct = 1'b0;
          sub_v  = 1'b1;
          a_v    = ONE17 - {1'b0, sus};
          b_v    = {1'b0, cnt_q};
        end
        if (cnt1 >= {1'b0, n}) begin
          stage_d = ST_SUSTAIN;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt1[15:0];
        end
      end
      ST_SUSTAIN: begin
        env_dir = sus;
      end
      ST_RELEASE: begin
        n = len_r;
        if (cnt1 >= {1'b0, n}) begin
          env_dir = '0;
          stage_d = ST_IDLE;
          cnt_d   = '0;
        end else begin
          direct = 1'b0;
          a_v    = {1'b0, sus};
          b_v    = {1'b0, n} - {1'b0, cnt_q};
          cnt_d  = cnt1[15:0];
        end
      end
      default: begin
        env_dir = '0;
      end
    endcase
  end

  // quarter-wave lookup at the current phase
  logic [TABLE_BITS-1:0] idx;
  logic [7:0]            j, jm;
  logic [15:0]           mag;
  logic [15:0]           sine_v;

  always_comb begin
    idx    = phase_q[PHASE_W-1 -: TABLE_BITS];
    j      = idx[7:0];
    jm     = 8'(9'd256 - {1'b0, j});
    if (idx[8]) begin
      mag = (j == '0) ? SINE_PEAK : QTAB[jm];
    end else begin
      mag = QTAB[j];
    end
    sine_v = idx[9] ? 16'(16'd0 - mag) : mag;
  end

  // shared multiplier: envelope ramp numerator, then sample scaling
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] mul_p;

  always_comb begin
    if (fsm_q == F_EMUL) begin
      mul_a = op_a_q;
      mul_b = op_b_q;
    end else begin
      mul_a = 17'(sine_q);
      mul_b = signed'({1'b0, env_q});
    end
    mul_p = mul_a * mul_b;
  end

  logic        div_done;
  logic [15:0] quot;

  wosc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (fsm_q == F_EMUL),
    .dividend_i (mul_p[31:0]),
    .divisor_i  (div_n_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q     <= F_IDLE;
      stage_q   <= ST_IDLE;
      cnt_q     <= '0;
      phase_q   <= '0;
      step_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (fsm_q == F_DONE && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (fsm_q)
        F_IDLE: begin
          if (in_xfer) begin
            case (op)
              OP_NOTE_ON: begin
                step_q  <= s_axis_tdata[PHASE_W-1:0];
                stage_q <= ST_ATTACK;
                cnt_q   <= '0;
              end
              OP_NOTE_OFF: begin
                stage_q <= ST_RELEASE;
                cnt_q   <= '0;
              end
              OP_TICK: begin
                stage_q <= stage_d;
                cnt_q   <= cnt_d;
                phase_q <= phase_q + step_q;
                fsm_q   <= direct ? F_SMUL : F_EMUL;
              end
              default: ;
            endcase
          end
        end
        F_EMUL: fsm_q <= F_DIV;
        F_DIV: begin
          if (div_done) begin
            fsm_q <= F_SMUL;
          end
        end
        F_SMUL: fsm_q <= F_DONE;
        F_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            fsm_q <= F_IDLE;
          end
        end
        default: fsm_q <= F_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (fsm_q == F_IDLE && in_xfer && op == OP_TICK) begin
      sine_q  <= signed'(sine_v);
      env_q   <= env_dir;
      op_a_q  <= signed'(a_v);
      op_b_q  <= signed'(b_v);
      div_n_q <= n;
      sub_q   <= sub_v;
    end
    if (fsm_q == F_DIV && div_done) begin
      env_q <= sub_q ? 16'(ONE17 - {1'b0, quot}) : quot;
    end
    if (fsm_q == F_SMUL) begin
      smp_q <= mul_p[30:15];
    end
    if (fsm_q == F_DONE && (!m_valid_q || m_axis_tready)) begin
      m_smp_q <= smp_q;
      m_env_q <= env_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_env_q, m_smp_q};

endmodule

// File: rtl/wosc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wosc_checker
// port-level checks for the wavetable oscillator, bound to the top level
// ---------------------------------------------------------------------------
`include "wavetable_oscillator_adsr_top_assert.svh"

module wosc_checker import wosc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,   // [1:0] operation
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata    // [15:0] sample_out, [31:16] envelope_level
);

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // a waiting result holds until its transfer
  `WOSC_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")

  // a tick keeps the block busy on the next cycle
  `WOSC_ASSERT(a_tick_busy, clk_i, rst_ni, in_xfer && s_axis_tuser == OP_TICK |=> !s_axis_tready, "ready right after a tick")

  // note events never start a result
  `WOSC_ASSERT(a_note_silent, clk_i, rst_ni, in_xfer && s_axis_tuser != OP_TICK |=> !$rose(m_axis_tvalid), "result after a note event")

  // envelope never exceeds one
  `WOSC_ASSERT(a_env_range, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[31:16] <= 16'h8000, "envelope above one")

  // no result shown in reset, valid may still be unknown at the first edge
  `WOSC_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> m_axis_tvalid !== 1'b1, "output valid during reset")

endmodule

bind wavetable_oscillator_adsr_top wosc_checker u_wosc_checker (.*);

// File: bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the wavetable oscillator with adsr envelope: a
// queue-fed driver offers tick and note events, a voice predictor tracks
// phase, envelope stage and registers and queues the expected samples, and a
// monitor compares every output transfer field by field
// ---------------------------------------------------------------------------
module tb;
  import wosc_pkg::*;

  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned STUCK_LIMIT   = 5000;
  localparam logic [63:0] Q30_UNIT      = 64'd1073741824;
  localparam logic [63:0] Q30_QUARTER   = 64'd1686629713;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_ATTACK  = 3'd1,
    ST_DECAY   = 3'd2,
    ST_SUSTAIN = 3'd3,
    ST_RELEASE = 3'd4
  } env_stage_e;

  typedef struct {
    op_e         op;
    logic [25:0] incr;
  } voice_event_t;

  typedef struct packed {
    logic [15:0] level;
    logic [15:0] sample;
  } osc_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_addr_i    = '0;
  logic [15:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // [25:0] note_increment, [31:26] zero
  logic [1:0]  s_axis_tuser  = '0;   // [1:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [15:0] sample_out, [31:16] envelope_level

  wavetable_oscillator_adsr_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  voice_event_t event_queue [$];
  osc_result_t  sample_queue [$];

  // voice model state
  logic signed [15:0] sine_rom [1024];
  logic [25:0]        phase_acc;
  logic [25:0]        phase_inc;
  env_stage_e         stage;
  logic [15:0]        stage_cnt;
  logic [15:0]        reg_attack;
  logic [15:0]        reg_decay;
  logic [15:0]        reg_sustain;
  logic [15:0]        reg_release;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          long_hold      = 1'b0;
  int unsigned hold_count     = 0;
  bit          in_xfer        = 1'b0;
  int unsigned stuck_cycles   = 0;
  int unsigned error_count    = 0;
  int unsigned items_queued   = 0;

  function automatic logic signed [15:0] sine_sample(input int unsigned idx);
    logic [63:0] p;
    logic [63:0] f;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] mag;
    logic [1:0]  quad;
    int unsigned divs [5];
    divs = '{110, 72, 42, 20, 6};
    p    = 64'(idx) << 22;
    quad = p[31:30];
    f    = p & (Q30_UNIT - 64'd1);
    if (quad[0]) begin
      f = Q30_UNIT - f;
    end
    x  = (f * Q30_QUARTER) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30_UNIT;
    for (int k = 0; k < 5; k++) begin
      t = Q30_UNIT - (((x2 * t) >> 30) / 64'(divs[k]));
    end
    t = (x * t) >> 30;
    if (t > Q30_UNIT) begin
      t = Q30_UNIT;
    end
    mag = (t * 64'd32767 + (64'd1 << 29)) >> 30;
    return quad[1] ? 16'(-mag) : mag[15:0];
  endfunction

  function automatic logic [31:0] stage_len(input logic [15:0] v);
    return (v == 16'd0) ? 32'd1 : 32'(v);
  endfunction

  // apply one accepted event; a tick queues the sample it must produce
  task automatic predict_voice(input op_e op, input logic [25:0] incr);
    logic [31:0] sus;
    logic [31:0] cnt;
    logic [31:0] span;
    logic [31:0] lvl;
    longint      prod;
    longint      smp;
    env_stage_e  nxt;
    bit          ramp;
    osc_result_t res;
    sus  = (reg_sustain > ENV_ONE) ? ENV_ONE : 32'(reg_sustain);
    cnt  = 32'(stage_cnt);
    span = 32'd1;
    nxt  = ST_IDLE;
    ramp = 1'b1;
    case (op)
      OP_NOTE_ON: begin
        phase_inc = incr;
        stage     = ST_ATTACK;
        stage_cnt = '0;
      end
      OP_NOTE_OFF: begin
        stage     = ST_RELEASE;
        stage_cnt = '0;
      end
      OP_TICK: begin
        case (stage)
          ST_ATTACK: begin
            span = stage_len(reg_attack);
            nxt  = ST_DECAY;
            lvl  = (cnt >= span) ? ENV_ONE : (cnt * ENV_ONE) / span;
          end
          ST_DECAY: begin
            span = stage_len(reg_decay);
            nxt  = ST_SUSTAIN;
            lvl  = (cnt >= span) ? sus : ENV_ONE - ((ENV_ONE - sus) * cnt) / span;
          end
          ST_RELEASE: begin
            span = stage_len(reg_release);
            nxt  = ST_IDLE;
            lvl  = (cnt >= span) ? 32'd0 : (sus * (span - cnt)) / span;
            // last release tick is already silent
            if (cnt + 1 >= span) begin
              lvl = 32'd0;
            end
          end
          ST_SUSTAIN: begin
            ramp = 1'b0;
            lvl  = sus;
          end
          default: begin
            ramp = 1'b0;
            lvl  = 32'd0;
          end
        endcase
        if (ramp) begin
          if (cnt + 1 >= span) begin
            stage     = nxt;
            stage_cnt = '0;
          end else begin
            stage_cnt = 16'(cnt + 1);
          end
        end
        prod       = longint'(sine_rom[phase_acc[25:16]]) * longint'(lvl);
        smp        = prod >>> 15;
        res.sample = smp[15:0];
        res.level  = lvl[15:0];
        sample_queue.push_back(res);
        phase_acc  = phase_acc + phase_inc;
      end
      default: begin
      end
    endcase
  endtask

  // input driver
  always @(negedge clk_i) begin : driver
    voice_event_t ev;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_xfer) begin
      if (event_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        ev = event_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, ev.incr};
        s_axis_tuser  <= ev.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output ready, with the long hold counted here
  always @(negedge clk_i) begin : receiver
    if (long_hold && hold_count < HOLD_CYCLES) begin
      m_axis_tready <= 1'b0;
      hold_count    <= hold_count + 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (!long_hold) begin
        hold_count <= 0;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    osc_result_t want;
    osc_result_t got;
    bit          out_xfer;
    in_xfer  = s_axis_tvalid && s_axis_tready;
    out_xfer = m_axis_tvalid && m_axis_tready;
    if (rst_ni) begin
      if (out_xfer) begin
        got = m_axis_tdata;
        if (sample_queue.size() == 0) begin
          $display("%0t tb: unexpected output transfer, data %h", $time, m_axis_tdata);
          error_count++;
        end else begin
          want = sample_queue.pop_front();
          if (got.sample !== want.sample) begin
            $display("%0t tb: sample_out expected %0d got %0d", $time,
                     $signed(want.sample), $signed(got.sample));
            error_count++;
          end
          if (got.level !== want.level) begin
            $display("%0t tb: envelope_level expected %0d got %0d", $time,
                     want.level, got.level);
            error_count++;
          end
        end
      end
      if (cfg_we_i) begin
        case (reg_e'(cfg_addr_i))
          REG_ATTACK:  reg_attack  = cfg_wdata_i;
          REG_DECAY:   reg_decay   = cfg_wdata_i;
          REG_SUSTAIN: reg_sustain = cfg_wdata_i;
          REG_RELEASE: reg_release = cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (in_xfer) begin
        predict_voice(op_e'(s_axis_tuser), s_axis_tdata[25:0]);
      end
      if (in_xfer || out_xfer ||
          (event_queue.size() == 0 && !s_axis_tvalid && sample_queue.size() == 0)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
    end
  end

  initial begin : watchdog
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("tb: done, errors");
    $finish;
  end

  task automatic push_event(input op_e op, input logic [25:0] incr);
    voice_event_t ev;
    ev.op   = op;
    ev.incr = incr;
    event_queue.push_back(ev);
    if (op != OP_UNUSED) begin
      items_queued++;
    end
  endtask

  task automatic push_ticks(input int unsigned n);
    repeat (n) push_event(OP_TICK, 26'($urandom()));
  endtask

  function automatic logic [25:0] rand_increment();
    case ($urandom_range(3))
      0:       return 26'($urandom());
      1:       return 26'($urandom_range(0, 1 << 18));
      2:       return 26'h3FFFFFF;
      default: return 26'($urandom_range(0, 3));
    endcase
  endfunction

  // mostly note-on, ticks, note-off, ticks, at times with a retrigger; the rest noise
  task automatic queue_phrases(input int unsigned target, input int unsigned span);
    int unsigned goal;
    goal = items_queued + target;
    while (items_queued < goal) begin
      if ($urandom_range(99) < 85) begin
        push_event(OP_NOTE_ON, rand_increment());
        push_ticks($urandom_range(span));
        if ($urandom_range(9) == 0) begin
          push_event(OP_NOTE_ON, rand_increment());
          push_ticks($urandom_range(span));
        end
        push_event(OP_NOTE_OFF, 26'($urandom()));
        push_ticks($urandom_range(span / 2 + 2));
      end else begin
        repeat ($urandom_range(1, 4)) push_event(op_e'($urandom_range(3)), 26'($urandom()));
      end
    end
  endtask

  // nothing in flight, then enough cycles for a note event still in the block
  task automatic settle();
    while (event_queue.size() != 0 || s_axis_tvalid || sample_queue.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input reg_e idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic program_envelope(input int unsigned a, input int unsigned d,
                                  input int unsigned s, input int unsigned r);
    write_register(REG_ATTACK, 16'(a));
    write_register(REG_DECAY, 16'(d));
    write_register(REG_SUSTAIN, 16'(s));
    write_register(REG_RELEASE, 16'(r));
  endtask

  initial begin : stimulus
    int unsigned a;
    int unsigned d;
    int unsigned s;
    int unsigned r;
    int unsigned span;
    for (int i = 0; i < 1024; i++) begin
      sine_rom[i] = sine_sample(i);
    end
    phase_acc   = '0;
    phase_inc   = '0;
    stage       = ST_IDLE;
    stage_cnt   = '0;
    reg_attack  = 16'd441;
    reg_decay   = 16'd4410;
    reg_sustain = 16'd22938;
    reg_release = 16'd8820;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed events on the reset register values
    push_ticks(1);
    push_event(OP_NOTE_OFF, 26'h3FFFFFF);  // release from idle
    push_ticks(2);
    push_event(OP_UNUSED, 26'h3FFFFFF);
    push_event(OP_NOTE_ON, 26'h3FFFFFF);   // phase wraps every tick
    push_ticks(4);
    push_event(OP_NOTE_ON, 26'd0);         // phase kept, step cleared
    push_ticks(2);
    push_event(OP_NOTE_ON, 26'h2AAAAAA);
    push_ticks(3);
    push_event(OP_NOTE_ON, 26'h1555555);
    push_ticks(3);
    push_event(OP_NOTE_OFF, 26'd0);
    push_ticks(2);
    settle();

    // zero lengths act as one, sustain above one clamps
    program_envelope(0, 0, 65535, 0);
    queue_phrases(30, 6);
    settle();

    send_idle_pct = 81;
    program_envelope(1, 1, 0, 1);
    queue_phrases(30, 8);
    settle();

    send_idle_pct  = 0;
    recv_stall_pct = 81;
    program_envelope(65535, 65535, 32768, 65535);
    queue_phrases(40, 30);
    settle();

    // registers shrunk below a running stage counter
    send_idle_pct  = 12;
    recv_stall_pct = 12;
    program_envelope(40, 40, 10000, 40);
    push_event(OP_NOTE_ON, 26'h0012345);
    push_ticks(10);
    settle();
    write_register(REG_ATTACK, 16'd5);
    push_ticks(13);
    settle();
    write_register(REG_DECAY, 16'd4);
    push_ticks(3);
    push_event(OP_NOTE_OFF, 26'd0);
    push_ticks(10);
    settle();
    write_register(REG_RELEASE, 16'd3);
    push_ticks(3);
    settle();

    // receiver holds off so the block backs up into its input
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    program_envelope(3, 5, 20000, 4);
    long_hold = 1'b1;
    queue_phrases(40, 14);
    settle();
    long_hold = 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      a = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
      d = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
      r = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
      s = ($urandom_range(9) == 0) ? $urandom_range(32769, 65535) : $urandom_range(0, 32768);
      program_envelope(a, d, s, r);
      span = a + d + r + 4;
      if (span > 40) begin
        span = 40;
      end
      queue_phrases(13, span);
      // sender waits for every result before the second half
      settle();
      queue_phrases(13, span);
      settle();
    end

    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/wosc_pkg.sv
rtl/wosc_div.sv
rtl/wavetable_oscillator_adsr_top.sv
rtl/wosc_checker.sv
bench/tb.sv
